/* design/burh_pkg.sv */
// Shared types and constants for the bounded undo/redo history core.
// Holds the command codes and the request/response beat structs.
// No dependencies.
package burh_pkg;

   localparam int DATA_W            = 64;
   localparam int LIMIT_W           = 7;
   localparam int COUNT_W           = 7;
   localparam int STORE_DEPTH_DEF   = 64;
   localparam int ENTRY_WIDTH_DEF   = 64;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd50;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_UNDO  = 2'd1,
      CMD_REDO  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type             command;
      logic [DATA_W-1:0]   entry_data;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   current_data;
      logic                entry_valid;
      logic                can_undo;
      logic                can_redo;
      logic [COUNT_W-1:0]  entry_count;
      logic [COUNT_W-1:0]  cursor_position;
   } rsp_type;

endpackage

/* design/burh_ram.sv */
// Generic single-port RAM with registered read data.
// One access per cycle: write when we is high, else read. No dependencies.
module burh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end else begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* design/bounded_undo_redo_history_core.sv */
// Top level of the bounded undo/redo history core.
// Uses burh_pkg (types, command codes, constants) and burh_ram (snapshot store).
//
//  channel   ports                          direction  handshake
//  request   start, busy, req_payload       in         beat taken when start && !busy
//  response  rsp_strobe, rsp_payload        out        one-cycle strobe, no back-pressure
//  config    csr_wr_en, csr_wr_data         in         history_limit written when csr_wr_en
//
// Cycles: one command per clock; busy is always low. The response beat for a
// command shows the cycle after it is taken, set by the registered read of the
// snapshot RAM (one access per command: write on push, read otherwise).
// Reset clears count, cursor and oldest slot and loads history_limit with 50;
// the snapshot RAM is not cleared, as only written slots ever reach current_data.
// The receiver cannot stall: every response beat lasts exactly one cycle.
module bounded_undo_redo_history_core #(
   parameter int STORE_DEPTH = burh_pkg::STORE_DEPTH_DEF,
   parameter int ENTRY_WIDTH = burh_pkg::ENTRY_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  burh_pkg::req_type                req_payload,
   output logic                             rsp_strobe,
   output burh_pkg::rsp_type                rsp_payload,
   input  logic                             csr_wr_en,
   input  logic [burh_pkg::LIMIT_W-1:0]     csr_wr_data
);

   localparam int AW     = $clog2(STORE_DEPTH);        // slot address
   localparam int CW     = $clog2(STORE_DEPTH + 1);    // count and cursor
   localparam int SW     = CW + 1;                     // slot sum before wrap
   localparam int LIM_W  = burh_pkg::LIMIT_W;
   localparam int MW     = (CW + 1 > LIM_W) ? CW + 1 : LIM_W;
   localparam int DW     = burh_pkg::DATA_W;
   localparam int OUT_CW = burh_pkg::COUNT_W;

   // Architectural state
   logic [AW-1:0]    oldest_ff, oldest_in;
   logic [CW-1:0]    count_ff,  count_in;
   logic [CW-1:0]    cursor_ff, cursor_in;
   logic [LIM_W-1:0] limit_ff;

   // Response stage
   logic                   rsp_strobe_ff;
   logic                   rsp_push_ff;
   logic [ENTRY_WIDTH-1:0] rsp_word_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_undo_ff;
   logic                   rsp_redo_ff;
   logic [CW-1:0]          rsp_count_ff;
   logic [CW-1:0]          rsp_cursor_ff;

   logic                   accept;
   burh_pkg::cmd_type      cmd;
   logic [ENTRY_WIDTH-1:0] word;
   logic [MW-1:0]          eff_limit;
   logic                   push_drop;
   logic                   ram_we;
   logic [AW-1:0]          ram_addr;
   logic [ENTRY_WIDTH-1:0] ram_rdata;
   logic [ENTRY_WIDTH-1:0] data_sel;
   logic [DW-1:0]          data_ext;

   // Ring slot of (oldest + offset); offset stays below twice the depth.
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [CW-1:0] offset);
      logic [SW-1:0] sum;
      begin
         sum = SW'(base) + SW'(offset);
         if (sum >= SW'(STORE_DEPTH)) begin
            sum = sum - SW'(STORE_DEPTH);
         end
         return sum[AW-1:0];
      end
   endfunction

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign cmd    = req_payload.command;
   assign word   = req_payload.entry_data[ENTRY_WIDTH-1:0];

   // Clamp the limit into [1, STORE_DEPTH].
   always_comb begin
      eff_limit = MW'(limit_ff);
      if (eff_limit == '0) begin
         eff_limit = MW'(1);
      end
      if (eff_limit > MW'(STORE_DEPTH)) begin
         eff_limit = MW'(STORE_DEPTH);
      end
   end

   // Push past the limit drops exactly one oldest entry.
   assign push_drop = (MW'(cursor_ff) + MW'(1)) > eff_limit;

   // Next state and the one RAM access for this command
   always_comb begin
      oldest_in = oldest_ff;
      count_in  = count_ff;
      cursor_in = cursor_ff;
      ram_we    = 1'b0;
      ram_addr  = '0;
      case (cmd)
         burh_pkg::CMD_PUSH: begin
            // discard redo entries, append at the cursor
            ram_we   = accept;
            ram_addr = slot_of(oldest_ff, cursor_ff);
            if (push_drop) begin
               oldest_in = slot_of(oldest_ff, CW'(1));
               count_in  = cursor_ff;
               cursor_in = cursor_ff;
            end else begin
               count_in  = cursor_ff + CW'(1);
               cursor_in = cursor_ff + CW'(1);
            end
         end
         burh_pkg::CMD_UNDO: begin
            if (cursor_ff > CW'(1)) begin
               cursor_in = cursor_ff - CW'(1);
            end
         end
         burh_pkg::CMD_REDO: begin
            if (cursor_ff < count_ff) begin
               cursor_in = cursor_ff + CW'(1);
            end
         end
         default: begin
            oldest_in = '0;
            count_in  = '0;
            cursor_in = '0;
         end
      endcase
      // read the entry under the new cursor (push bypasses it)
      if (!ram_we) begin
         ram_addr = slot_of(oldest_ff, cursor_in - CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff     <= '0;
         count_ff      <= '0;
         cursor_ff     <= '0;
         limit_ff      <= burh_pkg::LIMIT_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (accept) begin
            oldest_ff <= oldest_in;
            count_ff  <= count_in;
            cursor_ff <= cursor_in;
         end
      end
   end

   // Response payload registers: no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_push_ff   <= (cmd == burh_pkg::CMD_PUSH);
         rsp_word_ff   <= word;
         rsp_valid_ff  <= (cursor_in != '0);
         rsp_undo_ff   <= (cursor_in > CW'(1));
         rsp_redo_ff   <= (cursor_in < count_in);
         rsp_count_ff  <= count_in;
         rsp_cursor_ff <= cursor_in;
      end
   end

   burh_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (word),
      .rdata (ram_rdata)
   );

   // Pick the pushed word or the RAM read; zero when history is empty.
   always_comb begin
      data_sel = rsp_push_ff ? rsp_word_ff : ram_rdata;
      data_ext = '0;
      if (rsp_valid_ff) begin
         data_ext[ENTRY_WIDTH-1:0] = data_sel;
      end
   end

   assign rsp_strobe                  = rsp_strobe_ff;
   assign rsp_payload.current_data    = data_ext;
   assign rsp_payload.entry_valid     = rsp_valid_ff;
   assign rsp_payload.can_undo        = rsp_undo_ff;
   assign rsp_payload.can_redo        = rsp_redo_ff;
   assign rsp_payload.entry_count     = OUT_CW'(rsp_count_ff);
   assign rsp_payload.cursor_position = OUT_CW'(rsp_cursor_ff);

   // Cursor never runs past the newest entry.
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= count_ff)
      else $error("cursor beyond held count");

   // Count never exceeds the store, and the oldest slot stays inside it.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STORE_DEPTH) && oldest_ff <= AW'(STORE_DEPTH - 1))
      else $error("count or oldest slot out of range");

   // Every taken command yields exactly one response beat next cycle.
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("missing response beat");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("response beat without command");

   // Clear empties the history and rewinds the ring.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      accept && cmd == burh_pkg::CMD_CLEAR |=>
         count_ff == '0 && cursor_ff == '0 && oldest_ff == '0)
      else $error("clear left history state");

endmodule

/* tb/tb.sv */
// Self-checking bench for bounded_undo_redo_history_core: drives directed command
// beats and random bursts, predicts every response beat and checks it field by field.
// Depends on burh_pkg and the core RTL only.
module tb;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS   = 150;
   localparam int SETTLE_CYCLES = 4;

   // Tracks the history exactly as the core should: a ring of snapshot words,
   // the oldest slot, the number held and the cursor (index plus one).
   class history_tracker;
      logic [burh_pkg::DATA_W-1:0]  snapshots [burh_pkg::STORE_DEPTH_DEF];
      int unsigned                  oldest;
      int unsigned                  held;
      int unsigned                  cursor;
      logic [burh_pkg::LIMIT_W-1:0] limit_reg;
      burh_pkg::rsp_type            expected_views [$];
      int unsigned                  errors;
      int unsigned                  views_checked;
      int unsigned                  deepest;
      int unsigned                  drops;
      int unsigned                  cmd_counts [4];

      function new();
         oldest        = 0;
         held          = 0;
         cursor        = 0;
         limit_reg     = burh_pkg::LIMIT_RESET;
         errors        = 0;
         views_checked = 0;
         deepest       = 0;
         drops         = 0;
         foreach (cmd_counts[i]) cmd_counts[i] = 0;
      endfunction

      // Apply one accepted command and queue the view the core must report.
      function void note_command(burh_pkg::req_type beat);
         burh_pkg::rsp_type view;
         int unsigned       lim;
         int unsigned       slot;
         lim = limit_reg;
         if (lim == 0) lim = 1;
         if (lim > burh_pkg::STORE_DEPTH_DEF) lim = burh_pkg::STORE_DEPTH_DEF;
         cmd_counts[beat.command]++;
         case (beat.command)
            burh_pkg::CMD_PUSH: begin
               // drop the redo tail, append, then trim one oldest entry if over
               held = cursor;
               slot = (oldest + held) % burh_pkg::STORE_DEPTH_DEF;
               snapshots[slot] = beat.entry_data;
               held++;
               cursor = held;
               if (held > lim) begin
                  oldest = (oldest + 1) % burh_pkg::STORE_DEPTH_DEF;
                  held--;
                  cursor--;
                  drops++;
               end
            end
            burh_pkg::CMD_UNDO: if (cursor > 1) cursor--;
            burh_pkg::CMD_REDO: if (cursor < held) cursor++;
            burh_pkg::CMD_CLEAR: begin
               held   = 0;
               cursor = 0;
               oldest = 0;
            end
         endcase
         if (held > deepest) deepest = held;
         slot = (oldest + cursor - 1) % burh_pkg::STORE_DEPTH_DEF;
         view.current_data    = (cursor != 0) ? snapshots[slot] : '0;
         view.entry_valid     = (cursor != 0);
         view.can_undo        = (cursor > 1);
         view.can_redo        = (cursor < held);
         view.entry_count     = burh_pkg::COUNT_W'(held);
         view.cursor_position = burh_pkg::COUNT_W'(cursor);
         expected_views.insert(expected_views.size(), view);
      endfunction

      function void compare_field(string name, logic [burh_pkg::DATA_W-1:0] want,
                                  logic [burh_pkg::DATA_W-1:0] seen);
         if (want !== seen) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
            errors++;
         end
      endfunction

      // Match a response beat against the oldest pending view.
      function void check_view(burh_pkg::rsp_type got);
         burh_pkg::rsp_type want;
         if (expected_views.size() == 0) begin
            $display("%0t: response beat with nothing expected, actual %h", $time, got);
            errors++;
            return;
         end
         want = expected_views.pop_front();
         views_checked++;
         compare_field("current_data", want.current_data, got.current_data);
         compare_field("entry_valid", want.entry_valid, got.entry_valid);
         compare_field("can_undo", want.can_undo, got.can_undo);
         compare_field("can_redo", want.can_redo, got.can_redo);
         compare_field("entry_count", want.entry_count, got.entry_count);
         compare_field("cursor_position", want.cursor_position, got.cursor_position);
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   burh_pkg::req_type            req_payload;
   logic                         rsp_strobe;
   burh_pkg::rsp_type            rsp_payload;
   logic                         csr_wr_en;
   logic [burh_pkg::LIMIT_W-1:0] csr_wr_data;

   history_tracker     tracker;
   int unsigned        cycle_count = 0;
   int unsigned        limit_writes = 0;

   // Limit settings walked after the directed part: both extremes of the
   // register, the saturation edge, zero, and a drop below a full history.
   logic [burh_pkg::LIMIT_W-1:0] limit_plan [10] = '{7'd64, 7'd127, 7'd5, 7'd0, 7'd65,
                                                     7'd1, 7'd100, 7'd2, 7'd33, 7'd50};

   bounded_undo_redo_history_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Sample at the rising edge: retire the response beat first, since it
   // always belongs to an earlier command, then note the command taken here.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) tracker.check_view(rsp_payload);
         if (start && !busy) tracker.note_command(req_payload);
         if (csr_wr_en) tracker.limit_reg = csr_wr_data;
      end
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still expected",
                  cycle_count, tracker.expected_views.size());
         $display("status: fail");
         $finish;
      end
   end

   // Present one command beat at the falling edge and hold it until taken.
   task automatic send(input burh_pkg::cmd_type cmd,
                       input logic [burh_pkg::DATA_W-1:0] word);
      @(negedge clock);
      start       <= 1'b1;
      req_payload <= '{command: cmd, entry_data: word};
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Drop start for the given number of cycles.
   task automatic rest(input int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // Idle until every predicted beat has come back, then let the pipe drain.
   task automatic wait_quiet();
      rest(1);
      while (tracker.expected_views.size() != 0) @(posedge clock);
      rest(SETTLE_CYCLES);
   endtask

   task automatic write_limit(input logic [burh_pkg::LIMIT_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      limit_writes++;
   endtask

   // Mostly random words, with the all-zero and all-one words mixed in.
   function automatic logic [burh_pkg::DATA_W-1:0] random_word();
      case ($urandom_range(15))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Lean on push so histories grow deep; keep clear rare.
   function automatic burh_pkg::cmd_type pick_command();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 48) return burh_pkg::CMD_PUSH;
      if (roll < 73) return burh_pkg::CMD_UNDO;
      if (roll < 96) return burh_pkg::CMD_REDO;
      return burh_pkg::CMD_CLEAR;
   endfunction

   // Issue random commands in bursts. Some bursts are long straight runs of
   // undo or redo, which walk the cursor onto the oldest or newest entry.
   task automatic run_random(input int unsigned items);
      int unsigned       sent;
      int unsigned       burst;
      bit                straight;
      burh_pkg::cmd_type run_cmd;
      burh_pkg::cmd_type cmd;
      sent = 0;
      while (sent < items) begin
         straight = ($urandom_range(6) == 0);
         run_cmd  = ($urandom_range(1) != 0) ? burh_pkg::CMD_UNDO : burh_pkg::CMD_REDO;
         burst    = straight ? $urandom_range(8, 70) : $urandom_range(1, 24);
         repeat (burst) begin
            cmd = straight ? run_cmd : pick_command();
            send(cmd, random_word());
            sent++;
         end
         // skip the gap now and then so bursts run back to back
         if ($urandom_range(2) != 0) rest($urandom_range(1, 6));
      end
   endtask

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      tracker     = new();
      limit_plan[8] = burh_pkg::LIMIT_W'($urandom_range(1, 64));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty history, oldest and newest edges, redo tail discard,
      // clear, and the extreme data words. Limit stays at its reset value.
      send(burh_pkg::CMD_UNDO, '1);
      send(burh_pkg::CMD_REDO, '0);
      send(burh_pkg::CMD_CLEAR, '1);
      send(burh_pkg::CMD_PUSH, '0);
      send(burh_pkg::CMD_UNDO, '1);
      send(burh_pkg::CMD_PUSH, '1);
      send(burh_pkg::CMD_PUSH, 64'haaaa_aaaa_aaaa_aaaa);
      send(burh_pkg::CMD_PUSH, 64'h5555_5555_5555_5555);
      send(burh_pkg::CMD_REDO, '0);
      rest(2);
      send(burh_pkg::CMD_UNDO, '0);
      send(burh_pkg::CMD_UNDO, '0);
      send(burh_pkg::CMD_UNDO, '0);
      send(burh_pkg::CMD_UNDO, '0);
      send(burh_pkg::CMD_REDO, '0);
      send(burh_pkg::CMD_REDO, '0);
      send(burh_pkg::CMD_PUSH, random_word());
      send(burh_pkg::CMD_REDO, '0);
      send(burh_pkg::CMD_CLEAR, '0);
      rest(1);
      send(burh_pkg::CMD_UNDO, '0);
      send(burh_pkg::CMD_REDO, '1);
      send(burh_pkg::CMD_PUSH, random_word());
      send(burh_pkg::CMD_CLEAR, '0);

      run_random(PHASE_ITEMS);

      // Walk the limit settings; the history carries over between phases, so
      // a lowered limit meets a history that is already longer than it.
      foreach (limit_plan[i]) begin
         wait_quiet();
         write_limit(limit_plan[i]);
         run_random(PHASE_ITEMS);
      end

      wait_quiet();
      $display("covered %0d commands (push %0d, undo %0d, redo %0d, clear %0d)",
               tracker.cmd_counts[burh_pkg::CMD_PUSH] +
               tracker.cmd_counts[burh_pkg::CMD_UNDO] +
               tracker.cmd_counts[burh_pkg::CMD_REDO] +
               tracker.cmd_counts[burh_pkg::CMD_CLEAR],
               tracker.cmd_counts[burh_pkg::CMD_PUSH],
               tracker.cmd_counts[burh_pkg::CMD_UNDO],
               tracker.cmd_counts[burh_pkg::CMD_REDO],
               tracker.cmd_counts[burh_pkg::CMD_CLEAR]);
      $display("%0d limit writes, %0d beats checked, deepest %0d, dropped %0d, %0d mismatches",
               limit_writes, tracker.views_checked, tracker.deepest, tracker.drops,
               tracker.errors);
      if (tracker.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
